// ----- sv/clmd_pkg.sv -----
// ----------------------------------------------------------------------------
// clmd_pkg
// Shared types and constants of the content-length message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package clmd_pkg;

    // Length field width and its saturation value
    localparam int LEN_W = 27;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Reset value of the max_length register (100 MiB)
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = LEN_W'(104857600);

    // Register byte addresses
    localparam logic [1:0] ADDR_MAX_LENGTH = 2'd0;

    // Header prefix "Content-Length: "
    localparam int PREFIX_LEN = 16;

    // Character codes
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_C     = 8'h43;

    // Result status codes
    typedef enum logic [1:0] {
        ST_BODY       = 2'd0,
        ST_NO_LENGTH  = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_STREAM_END = 2'd3
    } status_t;

    // Value parse phase, one-hot
    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_SPACE  = 5'b00010,
        PH_SIGN   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_ENDED  = 5'b10000
    } phase_t;

    // Header verdict from the scanner to the top level
    typedef struct packed {
        logic             done;
        status_t          status;
        logic [LEN_W-1:0] length;
    } verdict_t;

    // Prefix character at a match position
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/clmd_header_scan.sv -----
// ----------------------------------------------------------------------------
// clmd_header_scan
// Header phase scanner: prefix match, length parse, terminator and count.
// ----------------------------------------------------------------------------
`default_nettype none

module clmd_header_scan
    import clmd_pkg::*;
#(
    parameter int HEADER_BYTES = 4096
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             clear,
    input  wire logic [7:0]       data_byte,
    input  wire logic [LEN_W-1:0] max_length,
    output verdict_t              verdict
);

    localparam int CNT_W = $clog2(HEADER_BYTES);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(HEADER_BYTES - 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       term_reg, term_next;
    logic [4:0]       match_pos_reg, match_pos_next;
    phase_t           phase_reg, phase_next;
    logic             pending_cr_reg, pending_cr_next;
    logic             negative_reg, negative_next;
    logic             nul_reg, nul_next;
    logic [LEN_W-1:0] value_reg, value_next;
    logic             oversize_reg, oversize_next;

    // Scan results before the end-of-header clear
    logic [CNT_W-1:0] count_scan;
    logic [2:0]       term_scan;
    logic [4:0]       match_pos_scan;
    phase_t           phase_scan;
    logic             pending_cr_scan;
    logic             negative_scan;
    logic             nul_scan;
    logic [LEN_W-1:0] value_scan;
    logic             oversize_scan;

    logic             is_digit;
    logic             is_space;
    logic [LEN_W+3:0] acc;
    logic             acc_over;
    logic             done;

    // Byte classes and the times-ten accumulate
    always_comb
    begin
        is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
        is_space = (data_byte == CHAR_SPACE) ||
                   ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
        acc      = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0}
                 + {(LEN_W)'(0), data_byte[3:0] - CHAR_ZERO[3:0]};
        acc_over = oversize_reg || (acc > {4'b0000, LEN_MAX});
    end

    // Next state of the scanner
    always_comb
    begin
        count_scan      = count_reg + CNT_W'(1);
        match_pos_scan  = match_pos_reg;
        phase_scan      = phase_reg;
        pending_cr_scan = pending_cr_reg;
        negative_scan   = negative_reg;
        nul_scan        = nul_reg;
        value_scan      = value_reg;
        oversize_scan   = oversize_reg;

        // prefix match and value parse; a zero byte stops both
        if (!nul_reg)
        begin
            if (data_byte == CHAR_NUL)
            begin
                nul_scan = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (data_byte == prefix_char(match_pos_reg[3:0]))
                        begin
                            match_pos_scan = match_pos_reg + 5'd1;
                            if (match_pos_scan == 5'(PREFIX_LEN))
                                phase_scan = PH_SPACE;
                        end
                        else
                        begin
                            match_pos_scan = (data_byte == CHAR_C) ? 5'd1 : 5'd0;
                        end
                    end
                    PH_SPACE:
                    begin
                        if (pending_cr_reg && (data_byte == CHAR_LF))
                        begin
                            phase_scan = PH_ENDED;
                        end
                        else if (is_space)
                        begin
                            pending_cr_scan = (data_byte == CHAR_CR);
                        end
                        else if ((data_byte == CHAR_PLUS) || (data_byte == CHAR_MINUS))
                        begin
                            negative_scan = (data_byte == CHAR_MINUS);
                            phase_scan    = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            oversize_scan = acc_over;
                            value_scan    = acc_over ? LEN_MAX : acc[LEN_W-1:0];
                            phase_scan    = PH_DIGITS;
                        end
                        else
                        begin
                            phase_scan = PH_ENDED;
                        end
                        if (phase_scan != PH_SPACE)
                            pending_cr_scan = 1'b0;
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            oversize_scan = acc_over;
                            value_scan    = acc_over ? LEN_MAX : acc[LEN_W-1:0];
                            phase_scan    = PH_DIGITS;
                        end
                        else
                        begin
                            phase_scan = PH_ENDED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // CR LF CR LF tracking
        if ((term_reg == 2'd0) || (term_reg == 2'd2))
            term_scan = (data_byte == CHAR_CR) ? {1'b0, term_reg} + 3'd1 : 3'd0;
        else if (data_byte == CHAR_LF)
            term_scan = {1'b0, term_reg} + 3'd1;
        else
            term_scan = (data_byte == CHAR_CR) ? 3'd1 : 3'd0;

        done = (term_scan == 3'd4) || (count_scan == COUNT_LIMIT);

        // Verdict on the byte that ends the header
        verdict.done   = step && done;
        verdict.length = value_scan;
        if (phase_scan == PH_SEARCH)
            verdict.status = ST_NO_LENGTH;
        else if (negative_scan || oversize_scan || (value_scan == '0) ||
                 (value_scan > max_length))
            verdict.status = ST_BAD_LENGTH;
        else
            verdict.status = ST_BODY;

        // Commit, or clear after a header end or a stream end
        if (clear || (step && done))
        begin
            count_next      = '0;
            term_next       = 2'd0;
            match_pos_next  = 5'd0;
            phase_next      = PH_SEARCH;
            pending_cr_next = 1'b0;
            negative_next   = 1'b0;
            nul_next        = 1'b0;
            value_next      = '0;
            oversize_next   = 1'b0;
        end
        else if (step)
        begin
            count_next      = count_scan;
            term_next       = term_scan[1:0];
            match_pos_next  = match_pos_scan;
            phase_next      = phase_scan;
            pending_cr_next = pending_cr_scan;
            negative_next   = negative_scan;
            nul_next        = nul_scan;
            value_next      = value_scan;
            oversize_next   = oversize_scan;
        end
        else
        begin
            count_next      = count_reg;
            term_next       = term_reg;
            match_pos_next  = match_pos_reg;
            phase_next      = phase_reg;
            pending_cr_next = pending_cr_reg;
            negative_next   = negative_reg;
            nul_next        = nul_reg;
            value_next      = value_reg;
            oversize_next   = oversize_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            term_reg       <= 2'd0;
            match_pos_reg  <= 5'd0;
            phase_reg      <= PH_SEARCH;
            pending_cr_reg <= 1'b0;
            negative_reg   <= 1'b0;
            nul_reg        <= 1'b0;
            value_reg      <= '0;
            oversize_reg   <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            term_reg       <= term_next;
            match_pos_reg  <= match_pos_next;
            phase_reg      <= phase_next;
            pending_cr_reg <= pending_cr_next;
            negative_reg   <= negative_next;
            nul_reg        <= nul_next;
            value_reg      <= value_next;
            oversize_reg   <= oversize_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/content_length_message_deframer_top.sv -----
// ----------------------------------------------------------------------------
// content_length_message_deframer_top
// Splits a byte stream into bodies framed by a "Content-Length: " header.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_*       in         s_tvalid / s_tready          data_byte, end_of_stream
//  m_*       out        m_tvalid / m_tready          body_byte, last, status
//  apb       in         psel, penable, pwrite, pready max_length at 0x0
//
//  One byte per cycle while s_tready is high: a byte is handled in the cycle it
//  is accepted; its result, if any, is held in the output register next cycle.
//  s_tready is high while the output register is empty or being taken.
//  Header bytes give a result only when a header ends with no valid length.
//  rst_n clears all control state and sets max_length to 104857600.
// ----------------------------------------------------------------------------
`default_nettype none

module content_length_message_deframer_top
    import clmd_pkg::*;
#(
    parameter int HEADER_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] end_of_stream
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] body_byte
    output logic             m_tlast,   // last
    output logic [1:0]       m_tuser,   // [1:0] status
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [LEN_W-1:0] max_length_reg;
    logic             in_body_reg, in_body_next;
    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    status_t          out_status_reg, out_status_next;

    logic             accept;
    logic             scan_step;
    logic             scan_clear;
    logic [LEN_W-1:0] remaining_dec;
    verdict_t         verdict;

    // APB register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_LENGTH) ? {(32 - LEN_W)'(0), max_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RESET;
        else if (psel && penable && pwrite && pready && (paddr == ADDR_MAX_LENGTH))
            max_length_reg <= pwdata[LEN_W-1:0];
    end

    // Input handshake
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign scan_step  = accept && !s_tuser && !in_body_reg;
    assign scan_clear = accept && s_tuser;

    clmd_header_scan #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (scan_step),
        .clear      (scan_clear),
        .data_byte  (s_tdata),
        .max_length (max_length_reg),
        .verdict    (verdict)
    );

    // Body counter, phase and result selection
    always_comb
    begin
        remaining_dec   = (remaining_reg != '0) ? remaining_reg - LEN_W'(1) : remaining_reg;
        in_body_next    = in_body_reg;
        remaining_next  = remaining_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        if (accept)
        begin
            if (s_tuser)
            begin
                // stream end in either phase
                in_body_next    = 1'b0;
                remaining_next  = '0;
                out_valid_next  = 1'b1;
                out_byte_next   = 8'd0;
                out_last_next   = 1'b0;
                out_status_next = ST_STREAM_END;
            end
            else if (in_body_reg)
            begin
                remaining_next  = remaining_dec;
                in_body_next    = (remaining_dec != '0);
                out_valid_next  = 1'b1;
                out_byte_next   = s_tdata;
                out_last_next   = (remaining_dec == '0);
                out_status_next = ST_BODY;
            end
            else if (verdict.done)
            begin
                if (verdict.status == ST_BODY)
                begin
                    // valid length: body starts with the next byte
                    in_body_next   = 1'b1;
                    remaining_next = verdict.length;
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = 8'd0;
                    out_last_next   = 1'b0;
                    out_status_next = verdict.status;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg   <= 1'b0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_body_reg   <= in_body_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire
